[hdl/sa_pkg.sv]
// shared types and constants for the slab allocator
// holds transaction structs, controller/datapath links and register map
package sa_pkg;

  localparam int FREE_DEPTH_DEF = 1024;
  localparam int ADDR_BITS_DEF  = 32;
  localparam int DATA_W         = 32;
  localparam int CFG_AW         = 4;

  localparam logic [DATA_W-1:0] OBJ_BYTES_RST = 32'd16;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_BYTES = 2'd1;
  localparam logic [1:0] REG_OBJ   = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] freed_address;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] granted_address;
    logic              granted;
    logic              overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // latch the accepted request
    logic exec;      // run pop read, bump, or push
    logic fetch;     // capture popped address into the result
    logic load_out;  // move the result to the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop;       // pending request pops the free stack
  } dp_sts_t;

endpackage

[hdl/sa_ctrl.sv]
// controller state machine for the slab allocator
// depends on sa_pkg for the command and status structs
module sa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sa_pkg::dp_sts_t    sts,
  output sa_pkg::ctrl_cmd_t  cmd
);
  import sa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_POST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    // result register drains independently of the request side
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.pop ? S_FETCH : S_POST;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/sa_dpath.sv]
// datapath for the slab allocator: config registers, bump offset,
// free stack memory with its count, and the result registers; uses sa_pkg
module sa_dpath #(
  parameter int FREE_DEPTH = sa_pkg::FREE_DEPTH_DEF,
  parameter int ADDR_BITS  = sa_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sa_pkg::CFG_AW-1:0]       paddr,
  input  logic [sa_pkg::DATA_W-1:0]       pwdata,
  output logic [sa_pkg::DATA_W-1:0]       prdata,
  input  sa_pkg::in_item_t                in_data,
  output sa_pkg::out_item_t               out_data,
  input  sa_pkg::ctrl_cmd_t               cmd,
  output sa_pkg::dp_sts_t                 sts
);
  import sa_pkg::*;

  localparam int IW   = $clog2(FREE_DEPTH);
  localparam int CW   = $clog2(FREE_DEPTH + 1);
  localparam int KEEP = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
  localparam logic [DATA_W-1:0] ADDR_MASK = {DATA_W{1'b1}} >> (DATA_W - KEEP);

  logic [DATA_W-1:0] base_r, region_r, obj_r;
  logic [DATA_W-1:0] bump_r;
  logic [CW-1:0]     count_r;
  in_item_t          item_r;
  out_item_t         res_r;
  out_item_t         out_r;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] mem [FREE_DEPTH];

  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic [DATA_W:0]   bump_end;
  logic              fits;
  logic              full;
  logic              empty;
  logic [CW-1:0]     count_dec;
  logic [DATA_W-1:0] bump_addr;
  logic              do_pop, do_push;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_BASE:  prdata = base_r;
      REG_BYTES: prdata = region_r;
      REG_OBJ:   prdata = obj_r;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      region_r <= '0;
      obj_r    <= OBJ_BYTES_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BASE:  base_r   <= pwdata;
        REG_BYTES: region_r <= pwdata;
        REG_OBJ:   obj_r    <= pwdata;
        default:   ;
      endcase
    end
  end

  // offset + size <= region covers both the exhausted and the normal case;
  // a zero-size object always fits
  assign bump_end  = {1'b0, bump_r} + {1'b0, obj_r};
  assign fits      = (obj_r == '0) || (bump_end <= {1'b0, region_r});
  assign bump_addr = (base_r + bump_r) & ADDR_MASK;
  assign full      = (count_r == CW'(FREE_DEPTH));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - 1'b1;

  assign sts.pop = (item_r.action == ACT_ALLOC) && !empty;
  assign do_pop  = cmd.exec && sts.pop;
  assign do_push = cmd.exec && (item_r.action == ACT_FREE) && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      if (item_r.action == ACT_ALLOC) begin
        if (!empty) begin
          count_r <= count_dec;
        end else if (fits) begin
          bump_r <= bump_end[DATA_W-1:0];
        end
      end else if (!full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // free stack storage, one port written, one read
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count_r[IW-1:0]] <= item_r.freed_address;
    end
    if (do_pop) begin
      rdata_r <= mem[count_dec[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= '0;
      if (item_r.action == ACT_ALLOC) begin
        if (empty && fits) begin
          res_r.granted_address <= bump_addr;
          res_r.granted         <= 1'b1;
        end
      end else begin
        res_r.overflow <= full;
      end
    end else if (cmd.fetch) begin
      res_r.granted_address <= rdata_r;
      res_r.granted         <= 1'b1;
      res_r.overflow        <= 1'b0;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

endmodule

[hdl/slab_allocator.sv]
// Slab allocator: hands out fixed-size objects from one region (base, size and
// object size set over the register port) and recycles freed addresses through
// a LIFO free stack of FREE_DEPTH entries kept in a single-port-write memory.
// Every request gives exactly one result transaction. Requests are handled one
// at a time by the controller: a bump allocation, a free or an overflowed free
// gives a valid result through the EXEC and POST states, and an allocation
// served from the free stack also passes FETCH, for the registered memory read.
// A new request can be taken in the cycle after the previous result is loaded
// into the output register, so requests never overlap; POST waits on a stalled
// output. Freed addresses are not checked; a free onto a full stack is dropped
// and flagged with overflow. No clearing pass follows reset.
module slab_allocator #(
  parameter int FREE_DEPTH = sa_pkg::FREE_DEPTH_DEF,
  parameter int ADDR_BITS  = sa_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sa_pkg::in_item_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sa_pkg::out_item_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sa_pkg::CFG_AW-1:0]  paddr,
  input  logic [sa_pkg::DATA_W-1:0]  pwdata,
  output logic [sa_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);
  import sa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign pready = 1'b1;

  sa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sa_dpath #(
    .FREE_DEPTH (FREE_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[hdl/sa_checker.sv]
// port-level checks for the slab allocator, bound to the top level
// depends on sa_pkg for the transaction structs
module sa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sa_pkg::out_item_t out_data
);
  import sa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: after an accept the input side stalls
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  a_grant_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.granted && out_data.overflow))
    else $error("granted and overflow both set");

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.granted |-> out_data.granted_address == '0)
    else $error("address nonzero without a grant");

endmodule

bind slab_allocator sa_checker u_sa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
